// ----- hw/rtl/npci_pkg.sv -----
// shared types, palette constants and state encoding for the palette index search
package npci_pkg;

    localparam int unsigned ChanW  = 8;
    localparam int unsigned DistW  = 18;
    localparam int unsigned DigitW = 3;
    localparam int unsigned RemW   = 6;

    localparam logic [ChanW-1:0] FirstIdx     = 8'd1;
    localparam logic [ChanW-1:0] CubeLastIdx  = 8'd216;
    localparam logic [ChanW-1:0] LastIdx      = 8'd255;
    localparam logic [ChanW-1:0] TranspIdx    = 8'h00;
    localparam logic [DigitW-1:0] DigitMax    = 3'd5;

    // gray j is floor(j*255/38): 255 = 6*38 + 27
    localparam logic [ChanW-1:0] GrayStep     = 8'd6;
    localparam logic [RemW-1:0]  GrayRemStep  = 6'd27;
    localparam logic [RemW-1:0]  GrayDivisor  = 6'd38;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic             valid;
        logic [ChanW-1:0] idx;
        logic [ChanW-1:0] pr;
        logic [ChanW-1:0] pg;
        logic [ChanW-1:0] pb;
    } t_dist_req;

    typedef struct packed {
        logic             valid;
        logic [ChanW-1:0] idx;
        logic [DistW-1:0] sq_dist;
    } t_dist_res;

    function automatic logic [ChanW-1:0] cube_level(input logic [DigitW-1:0] digit);
        logic [ChanW-1:0] lvl;
        case (digit)
            3'd0:    lvl = 8'd0;
            3'd1:    lvl = 8'd51;
            3'd2:    lvl = 8'd102;
            3'd3:    lvl = 8'd153;
            3'd4:    lvl = 8'd204;
            default: lvl = 8'd255;
        endcase
        return lvl;
    endfunction

endpackage

// ----- hw/rtl/npci_dist_unit.sv -----
// registered squared rgb distance between the pixel and one palette colour
module npci_dist_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [7:0]           i_red,
    input  logic [7:0]           i_green,
    input  logic [7:0]           i_blue,
    input  npci_pkg::t_dist_req  i_req,
    output npci_pkg::t_dist_res  o_res
);
    import npci_pkg::*;

    logic [ChanW-1:0]   w_dr;
    logic [ChanW-1:0]   w_dg;
    logic [ChanW-1:0]   w_db;
    logic [2*ChanW-1:0] w_sr;
    logic [2*ChanW-1:0] w_sg;
    logic [2*ChanW-1:0] w_sb;
    logic [DistW-1:0]   w_sum;
    logic               r_valid;
    logic [ChanW-1:0]   r_idx;
    logic [DistW-1:0]   r_dist;

    assign w_dr = (i_red   >= i_req.pr) ? (i_red   - i_req.pr) : (i_req.pr - i_red);
    assign w_dg = (i_green >= i_req.pg) ? (i_green - i_req.pg) : (i_req.pg - i_green);
    assign w_db = (i_blue  >= i_req.pb) ? (i_blue  - i_req.pb) : (i_req.pb - i_blue);
    assign w_sr = w_dr * w_dr;
    assign w_sg = w_dg * w_dg;
    assign w_sb = w_db * w_db;
    assign w_sum = {2'b00, w_sr} + {2'b00, w_sg} + {2'b00, w_sb};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid) begin
            r_idx  <= i_req.idx;
            r_dist <= w_sum;
        end
    end

    assign o_res.valid   = r_valid;
    assign o_res.idx     = r_idx;
    assign o_res.sq_dist = r_dist;

endmodule

// ----- hw/rtl/nearest_palette_color_index.sv -----
// top level: nearest palette index search over a fixed 255 colour palette
//
//  channel  dir  fields (low bit up)                  handshake
//  s_axis   in   red, green, blue, alpha (32 bits)    tvalid / tready
//  m_axis   out  palette_index (8 bits)               tvalid / tready
//
// an opaque pixel walks all 255 palette entries, one a cycle, through the shared
// distance unit; its registered result feeds the final compare, and the best index
// goes to the output register; a zero alpha word skips the search and goes to done
// tready is high only while no search runs; the result sits in an output
// register, so a new word is taken while it waits; reset clears control only
module nearest_palette_color_index (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // red[7:0], green[15:8], blue[23:16], alpha[31:24]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata    // palette_index[7:0]
);
    import npci_pkg::*;

    t_state            r_state;
    t_state            n_state;
    logic [ChanW-1:0]  r_red;
    logic [ChanW-1:0]  r_green;
    logic [ChanW-1:0]  r_blue;
    logic [ChanW-1:0]  r_idx;
    logic [DigitW-1:0] r_ri;
    logic [DigitW-1:0] r_gi;
    logic [DigitW-1:0] r_bi;
    logic              r_in_gray;
    logic [ChanW-1:0]  r_gray_v;
    logic [RemW-1:0]   r_gray_rem;
    logic [RemW:0]     w_rem_sum;
    logic [ChanW-1:0]  r_best_idx;
    logic [DistW-1:0]  r_best_dist;
    logic              r_out_valid;
    logic [ChanW-1:0]  r_out_idx;
    logic              w_accept;
    logic              w_transp;
    logic              w_issue;
    logic              w_load_out;
    logic              w_better;
    t_dist_req         w_req;
    t_dist_res         w_res;

    assign w_accept  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_transp  = (i_s_axis_tdata[31:24] == 8'h00);
    assign w_better  = w_res.valid &&
                       ((w_res.idx == FirstIdx) || (w_res.sq_dist < r_best_dist));
    assign w_rem_sum = {1'b0, r_gray_rem} + {1'b0, GrayRemStep};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = w_transp ? ST_DONE : ST_RUN;
                end
            end
            ST_RUN: begin
                if (r_idx == LastIdx) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (w_res.valid && (w_res.idx == LastIdx)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_s_axis_tready = 1'b0;
        w_issue         = 1'b0;
        w_load_out      = 1'b0;
        unique case (r_state)
            ST_IDLE:  o_s_axis_tready = 1'b1;
            ST_RUN:   w_issue         = 1'b1;
            ST_DRAIN: w_issue         = 1'b0;
            ST_DONE:  w_load_out      = !r_out_valid || i_m_axis_tready;
            default:  o_s_axis_tready = 1'b0;
        endcase
    end

    assign w_req.valid = w_issue;
    assign w_req.idx   = r_idx;
    assign w_req.pr    = r_in_gray ? r_gray_v : cube_level(r_ri);
    assign w_req.pg    = r_in_gray ? r_gray_v : cube_level(r_gi);
    assign w_req.pb    = r_in_gray ? r_gray_v : cube_level(r_bi);

    npci_dist_unit u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_red   (r_red),
        .i_green (r_green),
        .i_blue  (r_blue),
        .i_req   (w_req),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // candidate walk: cube digits, then gray ramp
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_red      <= i_s_axis_tdata[7:0];
            r_green    <= i_s_axis_tdata[15:8];
            r_blue     <= i_s_axis_tdata[23:16];
            r_idx      <= FirstIdx;
            r_ri       <= '0;
            r_gi       <= '0;
            r_bi       <= '0;
            r_in_gray  <= 1'b0;
            r_gray_v   <= '0;
            r_gray_rem <= '0;
        end else if (w_issue) begin
            r_idx <= r_idx + 8'd1;
            if (r_in_gray) begin
                if (w_rem_sum >= {1'b0, GrayDivisor}) begin
                    r_gray_v   <= r_gray_v + GrayStep + 8'd1;
                    r_gray_rem <= RemW'(w_rem_sum - {1'b0, GrayDivisor});
                end else begin
                    r_gray_v   <= r_gray_v + GrayStep;
                    r_gray_rem <= RemW'(w_rem_sum);
                end
            end else if (r_idx == CubeLastIdx) begin
                r_in_gray <= 1'b1;
            end else if (r_bi != DigitMax) begin
                r_bi <= r_bi + 3'd1;
            end else begin
                r_bi <= '0;
                if (r_gi != DigitMax) begin
                    r_gi <= r_gi + 3'd1;
                end else begin
                    r_gi <= '0;
                    r_ri <= r_ri + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_best_idx  <= TranspIdx;
            r_best_dist <= '0;
        end else if (w_better) begin
            r_best_idx  <= w_res.idx;
            r_best_dist <= w_res.sq_dist;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_idx <= r_best_idx;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_idx;

`ifndef NO_ASSERTIONS
    a_no_accept_during_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> !w_res.valid)
        else $error("input taken while distances still in flight");

    a_transparent_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_transp) |=> (r_best_idx == TranspIdx) && (r_state == ST_DONE))
        else $error("zero alpha word did not go straight to result");

    a_gray_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_issue |-> ((r_idx <= CubeLastIdx) == !r_in_gray))
        else $error("candidate phase out of step with index");

    a_drain_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && r_idx == LastIdx) |=> ##1 (r_state == ST_DONE))
        else $error("search did not finish after last entry");
`endif

endmodule

// ----- verif/nearest_palette_color_index_test.sv -----
// testbench for the nearest palette colour index block: predicts each index and checks every result
`timescale 1ns / 100ps

module nearest_palette_color_index_test;

    import npci_pkg::*;

    localparam int RandomItems = 1925;
    localparam int PauseAt     = 1000;
    localparam int HoldAfter   = 40;
    localparam int HoldCycles  = 800;
    localparam int DrainCycles = 300;
    localparam int IdleLimit   = 6000;

    class index_scoreboard;
        typedef struct {
            logic [31:0] pixel;
            logic [7:0]  index;
        } t_index_expect;

        t_index_expect expected_q[$];
        int            errors;
        int            results;

        function new();
            errors  = 0;
            results = 0;
        endfunction

        function automatic logic [7:0] nearest_index(input logic [31:0] pixel);
            int         r, g, b, pr, pg, pb, k, d, best_d;
            logic [7:0] best;
            r = pixel[7:0];
            g = pixel[15:8];
            b = pixel[23:16];
            if (pixel[31:24] == 8'd0) return TranspIdx;
            best   = FirstIdx;
            best_d = -1;
            for (int i = 1; i < 256; i++) begin
                if (i <= 216) begin
                    k  = i - 1;
                    pr = (k / 36) * 51;
                    pg = ((k / 6) % 6) * 51;
                    pb = (k % 6) * 51;
                end else begin
                    pr = ((i - 217) * 255) / 38;
                    pg = pr;
                    pb = pr;
                end
                d = (r - pr) * (r - pr) + (g - pg) * (g - pg) + (b - pb) * (b - pb);
                // first entry at the minimum is kept
                if (best_d < 0 || d < best_d) begin
                    best_d = d;
                    best   = i[7:0];
                end
            end
            return best;
        endfunction

        function void note_pixel(input logic [31:0] pixel);
            t_index_expect e;
            e.pixel = pixel;
            e.index = nearest_index(pixel);
            expected_q.push_back(e);
        endfunction

        function void check_index(input logic [7:0] actual);
            t_index_expect e;
            results++;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected palette index word: expected none, actual %0d",
                         $time, actual);
                errors++;
            end else begin
                e = expected_q.pop_front();
                if (actual !== e.index) begin
                    $display("%0t: palette index for pixel %h: expected %0d, actual %0d",
                             $time, e.pixel, e.index, actual);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [31:0] s_tdata = 32'd0;
    logic        m_tready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [7:0]  o_m_axis_tdata;

    index_scoreboard sb = new();

    int burst_left = 0;
    int quiet_left = 0;
    int idle_cycles = 0;

    nearest_palette_color_index dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && s_tvalid && o_s_axis_tready) begin
            sb.note_pixel(s_tdata);
        end
        if (i_rst_n && o_m_axis_tvalid && m_tready) begin
            sb.check_index(o_m_axis_tdata);
        end
        if ((s_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [31:0] pack_pixel(input int r, input int g, input int b,
                                               input int a);
        return {a[7:0], b[7:0], g[7:0], r[7:0]};
    endfunction

    function automatic int clamp_chan(input int v);
        return (v < 0) ? 0 : ((v > 255) ? 255 : v);
    endfunction

    function automatic logic [31:0] random_pixel();
        int kind, v, a;
        kind = $urandom_range(0, 99);
        a    = $urandom_range(1, 255);
        if (kind < 35) begin
            return pack_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                              $urandom_range(0, 255), a);
        end else if (kind < 55) begin
            // near the grey axis
            v = $urandom_range(0, 255);
            return pack_pixel(clamp_chan(v + $urandom_range(0, 6) - 3),
                              clamp_chan(v + $urandom_range(0, 6) - 3),
                              clamp_chan(v + $urandom_range(0, 6) - 3), a);
        end else if (kind < 80) begin
            // around cube levels
            return pack_pixel(clamp_chan($urandom_range(0, 5) * 51 + $urandom_range(0, 60) - 30),
                              clamp_chan($urandom_range(0, 5) * 51 + $urandom_range(0, 60) - 30),
                              clamp_chan($urandom_range(0, 5) * 51 + $urandom_range(0, 60) - 30),
                              a);
        end else begin
            return {8'd0, 24'($urandom())};
        end
    endfunction

    task automatic send_pixel(input logic [31:0] word, input int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    task automatic offer_pixel(input logic [31:0] word);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if (quiet_left > 0) begin
                quiet_left--;
            end else if ($urandom_range(0, 9) == 0) begin
                quiet_left = $urandom_range(3, 10);
            end else begin
                gap = $urandom_range(1, 12);
            end
        end
        burst_left--;
        send_pixel(word, gap);
    endtask

    // receiver: stall modes of random length, one long hold-off
    initial begin
        int  mode_left;
        int  stall_pct;
        int  hold_left;
        bit  held;
        mode_left = 0;
        stall_pct = 0;
        hold_left = 0;
        held      = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held && sb.results >= HoldAfter) begin
                held      = 1'b1;
                hold_left = HoldCycles;
            end
            if (mode_left == 0) begin
                mode_left = $urandom_range(50, 400);
                case ($urandom_range(0, 2))
                    0: begin
                        stall_pct = 0;
                    end
                    1: begin
                        stall_pct = 30;
                    end
                    default: begin
                        stall_pct = 75;
                    end
                endcase
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    initial begin
        while (idle_cycles < IdleLimit) @(posedge i_clk);
        $display("nearest_palette_color_index verification failed");
        $finish;
    end

    initial begin
        logic [31:0] directed_q[$];
        directed_q.push_back(pack_pixel(0, 0, 0, 0));
        directed_q.push_back(pack_pixel(255, 255, 255, 0));
        directed_q.push_back(pack_pixel(8'h55, 8'hAA, 8'h55, 0));
        directed_q.push_back(pack_pixel(0, 0, 0, 255));
        directed_q.push_back(pack_pixel(0, 0, 0, 1));
        directed_q.push_back(pack_pixel(255, 255, 255, 255));
        directed_q.push_back(pack_pixel(255, 0, 0, 8'h80));
        directed_q.push_back(pack_pixel(0, 255, 0, 8'h7F));
        directed_q.push_back(pack_pixel(0, 0, 255, 8'hFE));
        directed_q.push_back(pack_pixel(51, 102, 153, 255));
        directed_q.push_back(pack_pixel(204, 153, 102, 8'h01));
        directed_q.push_back(pack_pixel(127, 127, 127, 255));
        directed_q.push_back(pack_pixel(6, 6, 6, 255));
        directed_q.push_back(pack_pixel(248, 248, 248, 255));
        directed_q.push_back(pack_pixel(25, 25, 25, 255));
        directed_q.push_back(pack_pixel(26, 26, 26, 255));
        directed_q.push_back(pack_pixel(128, 128, 128, 255));
        directed_q.push_back(pack_pixel(8'h55, 8'hAA, 8'h55, 8'hAA));
        directed_q.push_back(pack_pixel(8'hAA, 8'h55, 8'hAA, 8'h55));
        directed_q.push_back(pack_pixel(255, 255, 0, 8'h7F));
        directed_q.push_back(pack_pixel(76, 76, 77, 200));
        directed_q.push_back(pack_pixel(0, 0, 0, 0));
        directed_q.push_back(pack_pixel(1, 2, 3, 0));
        directed_q.push_back(pack_pixel(254, 1, 128, 255));
        directed_q.push_back(pack_pixel(140, 140, 140, 255));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_q[i]) begin
            offer_pixel(directed_q[i]);
        end

        for (int n = 0; n < RandomItems; n++) begin
            if (n == PauseAt) begin
                // let the block drain completely before carrying on
                s_tvalid <= 1'b0;
                @(posedge i_clk);
                while (sb.pending() != 0) @(posedge i_clk);
            end
            offer_pixel(random_pixel());
        end

        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("nearest_palette_color_index verification clean");
        end else begin
            if (sb.pending() != 0) begin
                $display("%0t: %0d palette index words never arrived", $time, sb.pending());
            end
            $display("nearest_palette_color_index verification failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/npci_pkg.sv
hw/rtl/npci_dist_unit.sv
hw/rtl/nearest_palette_color_index.sv
verif/nearest_palette_color_index_test.sv
